// ----- design/glyph_page_framebuffer_writer_defines.svh -----
// Assertion macros used by the frame-store writer controller.
`ifndef GLYPH_PAGE_FRAMEBUFFER_WRITER_DEFINES_SVH
`define GLYPH_PAGE_FRAMEBUFFER_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPFW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPFW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/gpfw_pkg.sv -----
`default_nettype none

package gpfw_pkg;

    localparam int COLUMNS       = 128;
    localparam int PAGES         = 8;
    localparam int GLYPH_COLUMNS = 5;

    localparam int STORE_SIZE = COLUMNS * PAGES;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int COL_W      = $clog2(COLUMNS + GLYPH_COLUMNS);
    localparam int IDX_W      = $clog2(GLYPH_COLUMNS);
    localparam int ROW_W      = 6;
    localparam int BYTE_W     = 8;

    localparam int CMD_W      = 2;
    localparam int FIELD_W    = 8;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 8;

    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [ROW_W-1:0] ROW_SPACE = 6'd26;
    localparam logic [ROW_W-1:0] ROW_GT    = 6'd27;
    localparam logic [ROW_W-1:0] ROW_LT    = 6'd28;
    localparam logic [ROW_W-1:0] ROW_MINUS = 6'd29;
    localparam logic [ROW_W-1:0] ROW_DIGIT = 6'd30;

    typedef logic [GLYPH_COLUMNS*BYTE_W-1:0] t_glyph;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DRAW,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              ok;
        logic [ROW_W-1:0]  row;
    } t_glyph_sel;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [COL_W-1:0]  col;
        logic [IDX_W-1:0]  idx;
    } t_step_in;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_nxt;
        logic [COL_W-1:0]  col_nxt;
        logic [IDX_W-1:0]  idx_nxt;
        logic              col_ok;
        logic              addr_last;
        logic              idx_last;
    } t_step_out;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              status;
    } t_result;

    function automatic t_glyph_sel glyph_lookup(input logic [FIELD_W-1:0] code);
        t_glyph_sel sel;
        sel.ok  = 1'b1;
        sel.row = '0;
        if (code >= 8'h41 && code <= 8'h5A) begin
            sel.row = ROW_W'(code - 8'h41);
        end else if (code >= 8'h30 && code <= 8'h39) begin
            sel.row = ROW_DIGIT + ROW_W'(code - 8'h30);
        end else if (code == 8'h20) begin
            sel.row = ROW_SPACE;
        end else if (code == 8'h3E) begin
            sel.row = ROW_GT;
        end else if (code == 8'h3C) begin
            sel.row = ROW_LT;
        end else if (code == 8'h2D) begin
            sel.row = ROW_MINUS;
        end else begin
            sel.ok = 1'b0;
        end
        return sel;
    endfunction

    // Column 0 of a glyph sits in the lowest byte, bit 0 is the top pixel.
    function automatic t_glyph glyph_row(input logic [ROW_W-1:0] row);
        t_glyph g;
        case (row)
            6'd0:    g = 40'h7E0909097E;
            6'd1:    g = 40'h364949497F;
            6'd2:    g = 40'h224141413E;
            6'd3:    g = 40'h3E4141417F;
            6'd4:    g = 40'h414949497F;
            6'd5:    g = 40'h010909097F;
            6'd6:    g = 40'h7A4941413E;
            6'd7:    g = 40'h7F0808087F;
            6'd8:    g = 40'h41417F4141;
            6'd9:    g = 40'h3F41414020;
            6'd10:   g = 40'h412214087F;
            6'd11:   g = 40'h404040407F;
            6'd12:   g = 40'h7F0204027F;
            6'd13:   g = 40'h7F1008047F;
            6'd14:   g = 40'h3E4141413E;
            6'd15:   g = 40'h060909097F;
            6'd16:   g = 40'h5E2151413E;
            6'd17:   g = 40'h462919097F;
            6'd18:   g = 40'h3149494946;
            6'd19:   g = 40'h01017F0101;
            6'd20:   g = 40'h3F4040403F;
            6'd21:   g = 40'h1F2040201F;
            6'd22:   g = 40'h7F2018207F;
            6'd23:   g = 40'h6314081463;
            6'd24:   g = 40'h0708700807;
            6'd25:   g = 40'h4345495161;
            6'd26:   g = 40'h0000000000;
            6'd27:   g = 40'h0041221408;
            6'd28:   g = 40'h0008142241;
            6'd29:   g = 40'h0808080808;
            6'd30:   g = 40'h3E4549513E;
            6'd31:   g = 40'h00407F4200;
            6'd32:   g = 40'h4649516142;
            6'd33:   g = 40'h314B454121;
            6'd34:   g = 40'h107F121418;
            6'd35:   g = 40'h3945454527;
            6'd36:   g = 40'h3049494A3C;
            6'd37:   g = 40'h0305097101;
            6'd38:   g = 40'h3649494936;
            6'd39:   g = 40'h1E29494906;
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic logic [BYTE_W-1:0] glyph_byte(input logic [ROW_W-1:0] row,
                                                     input logic [IDX_W-1:0] idx);
        t_glyph g;
        g = glyph_row(row);
        return g[idx*BYTE_W +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

// ----- design/gpfw_ram.sv -----
`default_nettype none

module gpfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/gpfw_step_unit.sv -----
`default_nettype none

module gpfw_step_unit
    import gpfw_pkg::*;
(
    input  wire t_step_in  i_step,
    output t_step_out      o_step
);

    always_comb begin
        o_step.addr_nxt  = i_step.addr + 1'b1;
        o_step.col_nxt   = i_step.col + 1'b1;
        o_step.idx_nxt   = i_step.idx + 1'b1;
        o_step.col_ok    = i_step.col < COL_W'(COLUMNS);
        o_step.addr_last = i_step.addr == ADDR_W'(STORE_SIZE - 1);
        o_step.idx_last  = i_step.idx == IDX_W'(GLYPH_COLUMNS - 1);
    end

endmodule

`default_nettype wire

// ----- design/gpfw_ctrl.sv -----
`default_nettype none

`include "glyph_page_framebuffer_writer_defines.svh"

module gpfw_ctrl
    import gpfw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    output t_result                   o_res,
    input  wire logic                 i_res_ready,
    output t_mem_req                  o_mem,
    input  wire logic [BYTE_W-1:0]    i_mem_rdata
);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [COL_W-1:0]  r_col, n_col;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [BYTE_W-1:0] r_data, n_data;
    logic              r_status, n_status;
    logic              r_report, n_report;

    logic [CMD_W-1:0]   in_cmd;
    logic [FIELD_W-1:0] in_col;
    logic [FIELD_W-1:0] in_page;
    logic [FIELD_W-1:0] in_code;
    logic               accept;
    logic               in_range;
    t_glyph_sel         sel;
    logic [ADDR_W-1:0]  base;
    t_step_in           step_in;
    t_step_out          step;

    assign in_cmd  = i_s_tdata[CMD_W-1:0];
    assign in_col  = i_s_tdata[CMD_W +: FIELD_W];
    assign in_page = i_s_tdata[CMD_W+FIELD_W +: FIELD_W];
    assign in_code = i_s_tdata[CMD_W+2*FIELD_W +: FIELD_W];

    assign accept   = i_s_tvalid && o_s_tready;
    assign in_range = (9'(in_col) < 9'(COLUMNS)) && (9'(in_page) < 9'(PAGES));
    assign sel      = glyph_lookup(in_code);
    assign base     = ADDR_W'(32'(in_page) * COLUMNS + 32'(in_col));

    assign step_in.addr = r_addr;
    assign step_in.col  = r_col;
    assign step_in.idx  = r_idx;

    gpfw_step_unit u_step (
        .i_step (step_in),
        .o_step (step)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_DRAW:  n_state = (in_range && sel.ok) ? ST_DRAW : ST_DONE;
                        CMD_CLEAR: n_state = ST_CLEAR;
                        CMD_READ:  n_state = in_range ? ST_READ : ST_DONE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_DRAW: begin
                if (step.idx_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_CLEAR: begin
                if (step.addr_last) begin
                    n_state = r_report ? ST_DONE : ST_IDLE;
                end
            end
            ST_READ:      n_state = ST_READ_WAIT;
            ST_READ_WAIT: n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready  = r_state == ST_IDLE;
        o_mem.addr  = r_addr;
        o_mem.we    = ((r_state == ST_DRAW) && step.col_ok) || (r_state == ST_CLEAR);
        o_mem.wdata = (r_state == ST_DRAW) ? glyph_byte(r_row, r_idx) : '0;
        o_res.valid  = r_state == ST_DONE;
        o_res.data   = r_data;
        o_res.status = r_status;
    end

    always_comb begin
        n_addr   = r_addr;
        n_col    = r_col;
        n_idx    = r_idx;
        n_row    = r_row;
        n_data   = r_data;
        n_status = r_status;
        n_report = r_report;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_addr   = (in_cmd == CMD_CLEAR) ? '0 : base;
                    n_col    = COL_W'(in_col);
                    n_idx    = '0;
                    n_row    = sel.row;
                    n_data   = '0;
                    n_report = 1'b1;
                    case (in_cmd)
                        CMD_DRAW:  n_status = !(in_range && sel.ok);
                        CMD_CLEAR: n_status = 1'b0;
                        CMD_READ:  n_status = !in_range;
                        default:   n_status = 1'b1;
                    endcase
                end
            end
            ST_DRAW: begin
                n_addr = step.addr_nxt;
                n_col  = step.col_nxt;
                n_idx  = step.idx_nxt;
            end
            ST_CLEAR:     n_addr = step.addr_nxt;
            ST_READ_WAIT: n_data = i_mem_rdata;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_report <= n_report;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col    <= n_col;
        r_idx    <= n_idx;
        r_row    <= n_row;
        r_data   <= n_data;
        r_status <= n_status;
    end

    `GPFW_ASSERT_SAME(a_write_phase, i_clk, i_rst_n, o_mem.we,
        (r_state == ST_DRAW) || (r_state == ST_CLEAR), "store written outside draw or clear")
    `GPFW_ASSERT_NEXT(a_draw_done, i_clk, i_rst_n, (r_state == ST_DRAW) && step.idx_last,
        (r_state == ST_DONE) && !r_status, "draw did not finish with done status")
    `GPFW_ASSERT_NEXT(a_reset_clear_silent, i_clk, i_rst_n,
        (r_state == ST_CLEAR) && step.addr_last && !r_report,
        r_state == ST_IDLE, "clearing pass after reset produced a result")
    `GPFW_ASSERT_NEXT(a_bad_read, i_clk, i_rst_n, accept && (in_cmd == CMD_READ) && !in_range,
        (r_state == ST_DONE) && r_status && (r_data == '0), "bad read not flagged")

endmodule

`default_nettype wire

// ----- design/glyph_page_framebuffer_writer.sv -----
`default_nettype none

// Page-organized monochrome frame store (PAGES pages by COLUMNS columns, one byte of eight
// vertical pixels per column) with a built-in 5x7 glyph ROM. Every command beat yields exactly
// one result beat. All store traffic goes through one single-port RAM, one byte per cycle,
// stepped by an address counter (with a column counter for draws): a draw writes its glyph
// columns in ST_DRAW, a read passes ST_READ and ST_READ_WAIT, a clear writes every address
// in ST_CLEAR. After reset the store is cleared by such a pass, taking no command meanwhile.
// A finished result waits in the output register while the next command is accepted.
module glyph_page_framebuffer_writer
    import gpfw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // command[1:0], column[9:2], page[17:10], char_code[25:18], zero fill above.
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // read_data[7:0].
    output logic      [M_TDATA_W-1:0] o_m_tdata,
    // status[0].
    output logic      [0:0]           o_m_tuser
);

    t_result           res;
    t_mem_req          mem;
    logic [BYTE_W-1:0] mem_rdata;
    logic              res_ready;

    logic              r_m_valid, n_m_valid;
    logic [BYTE_W-1:0] r_m_data, n_m_data;
    logic              r_m_status, n_m_status;

    assign res_ready = !r_m_valid || i_m_tready;

    gpfw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem       (mem),
        .i_mem_rdata (mem_rdata)
    );

    gpfw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_addr  (mem.addr),
        .i_wdata (mem.wdata),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_m_valid  = r_m_valid;
        n_m_data   = r_m_data;
        n_m_status = r_m_status;
        if (res.valid && res_ready) begin
            n_m_valid  = 1'b1;
            n_m_data   = res.data;
            n_m_status = res.status;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data   <= n_m_data;
        r_m_status <= n_m_status;
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_m_tdata    = M_TDATA_W'(r_m_data);
    assign o_m_tuser[0] = r_m_status;

endmodule

`default_nettype wire

// ----- tb/frame_store_checker.sv -----
module frame_store_checker
    import gpfw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    // command[1:0], column[9:2], page[17:10], char_code[25:18], zero fill above.
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    // read_data[7:0].
    input  wire logic [M_TDATA_W-1:0] i_m_tdata,
    // status[0].
    input  wire logic [0:0]           i_m_tuser,
    output int                        o_mismatches,
    output int                        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       status;
    } t_reply;

    logic [7:0] pixels [STORE_SIZE];
    t_reply     replies_due [$];

    function automatic int glyph_index(input logic [7:0] code);
        if (code >= "A" && code <= "Z") return int'(code) - int'("A");
        if (code >= "0" && code <= "9") return 30 + int'(code) - int'("0");
        if (code == " ") return 26;
        if (code == ">") return 27;
        if (code == "<") return 28;
        if (code == "-") return 29;
        return -1;
    endfunction

    // The leftmost glyph column sits in the top byte.
    function automatic logic [39:0] glyph_columns(input int row);
        case (row)
            0:       return 40'h7E0909097E;
            1:       return 40'h7F49494936;
            2:       return 40'h3E41414122;
            3:       return 40'h7F4141413E;
            4:       return 40'h7F49494941;
            5:       return 40'h7F09090901;
            6:       return 40'h3E4141497A;
            7:       return 40'h7F0808087F;
            8:       return 40'h41417F4141;
            9:       return 40'h204041413F;
            10:      return 40'h7F08142241;
            11:      return 40'h7F40404040;
            12:      return 40'h7F0204027F;
            13:      return 40'h7F0408107F;
            14:      return 40'h3E4141413E;
            15:      return 40'h7F09090906;
            16:      return 40'h3E4151215E;
            17:      return 40'h7F09192946;
            18:      return 40'h4649494931;
            19:      return 40'h01017F0101;
            20:      return 40'h3F4040403F;
            21:      return 40'h1F2040201F;
            22:      return 40'h7F2018207F;
            23:      return 40'h6314081463;
            24:      return 40'h0708700807;
            25:      return 40'h6151494543;
            26:      return 40'h0000000000;
            27:      return 40'h0814224100;
            28:      return 40'h4122140800;
            29:      return 40'h0808080808;
            30:      return 40'h3E5149453E;
            31:      return 40'h00427F4000;
            32:      return 40'h4261514946;
            33:      return 40'h2141454B31;
            34:      return 40'h1814127F10;
            35:      return 40'h2745454539;
            36:      return 40'h3C4A494930;
            37:      return 40'h0171090503;
            38:      return 40'h3649494936;
            39:      return 40'h064949291E;
            default: return 40'h0;
        endcase
    endfunction

    function automatic t_reply apply_command(input logic [S_TDATA_W-1:0] beat);
        t_reply      res;
        logic [1:0]  cmd;
        logic [7:0]  col;
        logic [7:0]  pg;
        logic [7:0]  code;
        logic        in_range;
        int          row;
        logic [39:0] glyph;
        cmd      = beat[1:0];
        col      = beat[9:2];
        pg       = beat[17:10];
        code     = beat[25:18];
        res      = '{data: 8'h00, status: STATUS_IGNORED};
        in_range = (int'(col) < COLUMNS) && (int'(pg) < PAGES);
        case (cmd)
            CMD_DRAW: begin
                row = glyph_index(code);
                if (in_range && row >= 0) begin
                    glyph = glyph_columns(row);
                    for (int i = 0; i < GLYPH_COLUMNS; i++) begin
                        if (int'(col) + i < COLUMNS) begin
                            pixels[int'(pg) * COLUMNS + int'(col) + i] = glyph[39 - 8*i -: 8];
                        end
                    end
                    res.status = STATUS_DONE;
                end
            end
            CMD_CLEAR: begin
                for (int a = 0; a < STORE_SIZE; a++) begin
                    pixels[a] = 8'h00;
                end
                res.status = STATUS_DONE;
            end
            CMD_READ: begin
                if (in_range) begin
                    res.data   = pixels[int'(pg) * COLUMNS + int'(col)];
                    res.status = STATUS_DONE;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_reply want;
        if (!i_rst_n) begin
            replies_due.delete();
            for (int a = 0; a < STORE_SIZE; a++) begin
                pixels[a] = 8'h00;
            end
            o_mismatches = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (replies_due.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10) begin
                        $display("unexpected result beat: data %02h status %0d",
                                 i_m_tdata, i_m_tuser[0]);
                    end
                end else begin
                    want = replies_due.pop_front();
                    if (want.data != i_m_tdata || want.status != i_m_tuser[0]) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display("result mismatch: expected data %02h status %0d, got data %02h status %0d",
                                     want.data, want.status, i_m_tdata, i_m_tuser[0]);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                replies_due.push_back(apply_command(i_s_tdata));
            end
        end
        o_outstanding = replies_due.size();
    end

endmodule

// ----- tb/glyph_page_framebuffer_writer_tb.sv -----
module glyph_page_framebuffer_writer_tb;
    import gpfw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               STALL_LIMIT = 20000;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 s_tvalid   = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata    = '0;
    logic                 m_tready   = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    int mismatches;
    int outstanding;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    always #10 clk = ~clk;

    glyph_page_framebuffer_writer u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    frame_store_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always @(posedge clk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [7:0] col,
                                input logic [7:0] pg, input logic [7:0] code);
        int gap;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({code, pg, col, cmd});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [7:0]       col;
        logic [7:0]       pg;
        logic [7:0]       code;
        int               pick;
        int               glyph_n;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 20;
        snk_idle_pct = 20;
        send_command(CMD_READ,   8'd0,   8'd0,   8'h00);
        send_command(CMD_DRAW,   8'd0,   8'd0,   "A");
        send_command(CMD_READ,   8'd0,   8'd0,   8'h00);
        send_command(CMD_DRAW,   8'd127, 8'd7,   "Z");
        send_command(CMD_READ,   8'd127, 8'd7,   8'h00);
        send_command(CMD_DRAW,   8'd123, 8'd3,   "0");
        send_command(CMD_DRAW,   8'd124, 8'd3,   "9");
        send_command(CMD_READ,   8'd127, 8'd3,   8'h00);
        send_command(CMD_DRAW,   8'd10,  8'd1,   " ");
        send_command(CMD_DRAW,   8'd15,  8'd1,   ">");
        send_command(CMD_DRAW,   8'd20,  8'd1,   "<");
        send_command(CMD_DRAW,   8'd25,  8'd1,   "-");
        send_command(CMD_READ,   8'd25,  8'd1,   8'h00);
        send_command(CMD_DRAW,   8'd30,  8'd2,   8'h61);
        send_command(CMD_DRAW,   8'd30,  8'd2,   8'hFF);
        send_command(CMD_DRAW,   8'd30,  8'd2,   8'h00);
        send_command(CMD_DRAW,   8'd128, 8'd0,   "B");
        send_command(CMD_DRAW,   8'd0,   8'd8,   "C");
        send_command(CMD_DRAW,   8'd255, 8'd255, "D");
        send_command(CMD_READ,   8'd128, 8'd0,   8'hFF);
        send_command(CMD_READ,   8'd0,   8'd8,   8'h00);
        send_command(CMD_READ,   8'd255, 8'd255, 8'hFF);
        send_command(CMD_UNUSED, 8'd255, 8'd255, 8'hFF);
        send_command(CMD_CLEAR,  8'd255, 8'd255, 8'hFF);
        send_command(CMD_READ,   8'd0,   8'd0,   8'h00);
        drain_results();

        for (int chunk = 0; chunk < 8; chunk++) begin
            if (chunk == 7) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       src_idle_pct = 0;
                    1:       src_idle_pct = 5;
                    2:       src_idle_pct = 20;
                    default: src_idle_pct = 50;
                endcase
                case ($urandom_range(0, 3))
                    0:       snk_idle_pct = 0;
                    1:       snk_idle_pct = 5;
                    2:       snk_idle_pct = 20;
                    default: snk_idle_pct = 50;
                endcase
            end
            for (int n = 0; n < 250; n++) begin
                pick = $urandom_range(0, 199);
                cmd  = CMD_W'($urandom);
                col  = 8'($urandom);
                pg   = 8'($urandom);
                code = 8'($urandom);
                if (pick < 90) begin
                    cmd     = CMD_DRAW;
                    col     = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(120, 127))
                                                          : 8'($urandom_range(0, COLUMNS - 1));
                    pg      = 8'($urandom_range(0, PAGES - 1));
                    glyph_n = $urandom_range(0, 39);
                    if (glyph_n < 26) begin
                        code = 8'(8'h41 + glyph_n);
                    end else if (glyph_n < 36) begin
                        code = 8'(8'h30 + glyph_n - 26);
                    end else begin
                        case (glyph_n)
                            36:      code = " ";
                            37:      code = ">";
                            38:      code = "<";
                            default: code = "-";
                        endcase
                    end
                end else if (pick < 160) begin
                    cmd = CMD_READ;
                    col = 8'($urandom_range(0, COLUMNS - 1));
                    pg  = 8'($urandom_range(0, PAGES - 1));
                end else if (pick < 175) begin
                    cmd = CMD_DRAW;
                end else if (pick < 190) begin
                    cmd = CMD_READ;
                end else if (pick < 199) begin
                    cmd = CMD_UNUSED;
                end else begin
                    cmd = CMD_CLEAR;
                end
                send_command(cmd, col, pg, code);
            end
            if (chunk == 3) begin
                drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/gpfw_pkg.sv
design/gpfw_ram.sv
design/gpfw_step_unit.sv
design/gpfw_ctrl.sv
design/glyph_page_framebuffer_writer.sv
tb/frame_store_checker.sv
tb/glyph_page_framebuffer_writer_tb.sv
